// ===== hw/rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg: shared types and codes for the supersequence block
// Input action codes, controller command and datapath status groups.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int ACT_W       = 2;
    localparam int SYM_W       = 8;
    localparam int TOT_LEN_W   = 7;

    localparam logic [ACT_W-1:0] ACT_APPEND_A = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_B = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RUN      = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic append_a;
        logic append_b;
        logic run_start;
        logic fill_issue;
        logic tb_start;
        logic tb_read;
        logic tb_step;
        logic left_step;
        logic emit_read;
        logic emit_load;
        logic empty_load;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic both_empty;
        logic skip_fill;
        logic fill_last;
        logic tb_both;
        logic tb_any;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/scs_ctrl.sv =====
// ----------------------------------------------------------------------------
// scs_ctrl: sequencer for load, table fill, trace back and emit
// Drives datapath commands from the state and datapath status.
// ----------------------------------------------------------------------------
module scs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [scs_pkg::ACT_W-1:0]     action,
    input  scs_pkg::sts_t                 sts,
    output logic                          in_stall,
    output scs_pkg::cmd_t                 cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FILL     = 4'd1;
    localparam logic [3:0] S_FILL_END = 4'd2;
    localparam logic [3:0] S_TB_INIT  = 4'd3;
    localparam logic [3:0] S_TB_RD    = 4'd4;
    localparam logic [3:0] S_TB_DEC   = 4'd5;
    localparam logic [3:0] S_LEFT     = 4'd6;
    localparam logic [3:0] S_EMIT_RD  = 4'd7;
    localparam logic [3:0] S_EMIT_LD  = 4'd8;
    localparam logic [3:0] S_EMPTY    = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       in_fire;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (action)
                        scs_pkg::ACT_APPEND_A: cmd.append_a = 1'b1;
                        scs_pkg::ACT_APPEND_B: cmd.append_b = 1'b1;
                        scs_pkg::ACT_RUN:
                        begin
                            priority if (sts.both_empty)
                            begin
                                state_next = S_EMPTY;
                            end
                            else if (sts.skip_fill)
                            begin
                                state_next = S_TB_INIT;
                            end
                            else
                            begin
                                cmd.run_start = 1'b1;
                                state_next    = S_FILL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL:
            begin
                cmd.fill_issue = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = S_FILL_END;
                end
            end
            S_FILL_END: state_next = S_TB_INIT;
            S_TB_INIT:
            begin
                cmd.tb_start = 1'b1;
                state_next   = S_TB_RD;
            end
            S_TB_RD:
            begin
                priority if (sts.tb_both)
                begin
                    cmd.tb_read = 1'b1;
                    state_next  = S_TB_DEC;
                end
                else if (sts.tb_any)
                begin
                    state_next = S_LEFT;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_TB_DEC:
            begin
                cmd.tb_step = 1'b1;
                state_next  = S_TB_RD;
            end
            S_LEFT:
            begin
                if (sts.tb_any)
                begin
                    cmd.left_step = 1'b1;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_EMIT_LD;
                end
            end
            S_EMIT_LD:
            begin
                cmd.emit_load = 1'b1;
                if (sts.emit_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.empty_load = 1'b1;
                    cmd.finish     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/scs_dp.sv =====
// ----------------------------------------------------------------------------
// scs_dp: string storage, LCS table, trace back and output datapath
// Holds both strings, the table memory, the output buffer and result register.
// ----------------------------------------------------------------------------
module scs_dp #(
    parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [scs_pkg::SYM_W-1:0]       symbol,
    input  scs_pkg::cmd_t                   cmd,
    output scs_pkg::sts_t                   sts,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [scs_pkg::SYM_W-1:0]       out_symbol,
    output logic [scs_pkg::TOT_LEN_W-1:0]   total_length,
    output logic                            last_symbol,
    output logic                            is_empty,
    output logic                            overflowed
);

    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TOT_W     = $clog2(2 * MAX_LEN + 1);
    localparam int POS_W     = $clog2(2 * MAX_LEN);
    localparam int BUF_DEPTH = 2 * MAX_LEN;
    localparam int TBL_AW    = 2 * IDX_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int SYM_W     = scs_pkg::SYM_W;

    // string storage
    logic [SYM_W-1:0]  a_str_reg [MAX_LEN];
    logic [SYM_W-1:0]  b_str_reg [MAX_LEN];
    logic [CNT_W-1:0]  len_a_reg, len_a_next;
    logic [CNT_W-1:0]  len_b_reg, len_b_next;
    logic              ovf_reg, ovf_next;
    logic              a_wr, b_wr;

    // table fill
    logic [CNT_W-1:0]  fr_reg, fr_next;
    logic [CNT_W-1:0]  fc_reg, fc_next;
    logic              s1_valid_reg, s1_valid_next;
    logic [CNT_W-1:0]  s1_r_reg, s1_r_next;
    logic [CNT_W-1:0]  s1_c_reg, s1_c_next;
    logic              byp_reg, byp_next;
    logic [CNT_W-1:0]  byp_val_reg, byp_val_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [CNT_W-1:0]  diag_reg, diag_next;
    logic [CNT_W-1:0]  up1, left1, diag1, cell_val;

    logic [CNT_W-1:0]  tbl_mem [TBL_DEPTH];
    logic [CNT_W-1:0]  tbl_rd_a_reg;
    logic [CNT_W-1:0]  tbl_rd_b_reg;
    logic [TBL_AW-1:0] tbl_waddr, tbl_raddr_a, tbl_raddr_b;

    // trace back
    logic [CNT_W-1:0]  tb_r_reg, tb_r_next;
    logic [CNT_W-1:0]  tb_c_reg, tb_c_next;
    logic [TOT_W-1:0]  pos_reg, pos_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [TOT_W-1:0]  total_calc;
    logic [CNT_W-1:0]  lcs_len;
    logic [CNT_W-1:0]  tb_up, tb_left;
    logic              up_wins;
    logic              dec_r, dec_c;
    logic [SYM_W-1:0]  buf_wdata;
    logic              buf_we;

    // string read ports
    logic [IDX_W-1:0]  a_idx, b_idx;
    logic [SYM_W-1:0]  a_sym, b_sym;
    logic              sym_match;

    // output side
    logic [SYM_W-1:0]  buf_mem [BUF_DEPTH];
    logic [SYM_W-1:0]  buf_rd_reg;
    logic [POS_W-1:0]  k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]  out_symbol_reg;
    logic [TOT_W-1:0]  out_total_reg;
    logic              out_last_reg;
    logic              out_empty_reg;
    logic              out_ovf_reg;
    logic              emit_last;

    // share the string read ports between the fill stage and the trace back
    assign a_idx     = s1_valid_reg ? IDX_W'(s1_r_reg - CNT_W'(1)) : IDX_W'(tb_r_reg - CNT_W'(1));
    assign b_idx     = s1_valid_reg ? IDX_W'(s1_c_reg - CNT_W'(1)) : IDX_W'(tb_c_reg - CNT_W'(1));
    assign a_sym     = a_str_reg[a_idx];
    assign b_sym     = b_str_reg[b_idx];
    assign sym_match = (a_sym == b_sym);

    // fill stage: row and column zero of the table read as zero
    assign up1      = (s1_r_reg == CNT_W'(1)) ? '0 : (byp_reg ? byp_val_reg : tbl_rd_a_reg);
    assign left1    = (s1_c_reg == CNT_W'(1)) ? '0 : left_reg;
    assign diag1    = (s1_c_reg == CNT_W'(1)) ? '0 : diag_reg;
    assign cell_val = sym_match ? diag1 + CNT_W'(1) : ((up1 > left1) ? up1 : left1);

    assign tbl_waddr   = {IDX_W'(s1_r_reg - CNT_W'(1)), IDX_W'(s1_c_reg - CNT_W'(1))};
    assign tbl_raddr_a = cmd.fill_issue
                       ? {IDX_W'(fr_reg - CNT_W'(2)), IDX_W'(fc_reg - CNT_W'(1))}
                       : {IDX_W'(tb_r_reg - CNT_W'(2)), IDX_W'(tb_c_reg - CNT_W'(1))};
    assign tbl_raddr_b = {IDX_W'(tb_r_reg - CNT_W'(1)), IDX_W'(tb_c_reg - CNT_W'(2))};

    // trace back decision
    assign tb_up   = (tb_r_reg == CNT_W'(1)) ? '0 : tbl_rd_a_reg;
    assign tb_left = (tb_c_reg == CNT_W'(1)) ? '0 : tbl_rd_b_reg;
    assign up_wins = tb_up > tb_left;

    assign lcs_len    = sts.skip_fill ? '0 : left_reg;
    assign total_calc = TOT_W'(len_a_reg) + TOT_W'(len_b_reg) - TOT_W'(lcs_len);
    assign emit_last  = (TOT_W'(k_reg) + TOT_W'(1)) == total_reg;

    assign a_wr = cmd.append_a && (len_a_reg < CNT_W'(MAX_LEN));
    assign b_wr = cmd.append_b && (len_b_reg < CNT_W'(MAX_LEN));

    always_comb
    begin
        dec_r = 1'b0;
        dec_c = 1'b0;
        if (cmd.tb_step)
        begin
            dec_r = sym_match || up_wins;
            dec_c = sym_match || !up_wins;
        end
        else if (cmd.left_step)
        begin
            dec_r = (tb_r_reg != '0);
            dec_c = (tb_r_reg == '0);
        end
        buf_we    = cmd.tb_step || cmd.left_step;
        buf_wdata = dec_r ? a_sym : b_sym;
    end

    always_comb
    begin
        len_a_next     = len_a_reg;
        len_b_next     = len_b_reg;
        ovf_next       = ovf_reg;
        fr_next        = fr_reg;
        fc_next        = fc_reg;
        s1_valid_next  = cmd.fill_issue;
        s1_r_next      = s1_r_reg;
        s1_c_next      = s1_c_reg;
        byp_next       = byp_reg;
        byp_val_next   = byp_val_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        tb_r_next      = tb_r_reg;
        tb_c_next      = tb_c_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;

        if (a_wr)
        begin
            len_a_next = len_a_reg + CNT_W'(1);
        end
        if (b_wr)
        begin
            len_b_next = len_b_reg + CNT_W'(1);
        end
        if ((cmd.append_a && !a_wr) || (cmd.append_b && !b_wr))
        begin
            ovf_next = 1'b1;
        end

        if (cmd.run_start)
        begin
            fr_next = CNT_W'(1);
            fc_next = CNT_W'(1);
        end
        if (cmd.fill_issue)
        begin
            s1_r_next    = fr_reg;
            s1_c_next    = fc_reg;
            // cell above is being written this cycle: forward it
            byp_next     = s1_valid_reg && (s1_r_reg == fr_reg - CNT_W'(1))
                                        && (s1_c_reg == fc_reg);
            byp_val_next = cell_val;
            if (fc_reg == len_b_reg)
            begin
                fc_next = CNT_W'(1);
                fr_next = fr_reg + CNT_W'(1);
            end
            else
            begin
                fc_next = fc_reg + CNT_W'(1);
            end
        end
        if (s1_valid_reg)
        begin
            left_next = cell_val;
            diag_next = up1;
        end

        if (cmd.tb_start)
        begin
            tb_r_next  = len_a_reg;
            tb_c_next  = len_b_reg;
            total_next = total_calc;
            pos_next   = total_calc;
            k_next     = '0;
        end
        if (dec_r)
        begin
            tb_r_next = tb_r_reg - CNT_W'(1);
        end
        if (dec_c)
        begin
            tb_c_next = tb_c_reg - CNT_W'(1);
        end
        if (buf_we)
        begin
            pos_next = pos_reg - TOT_W'(1);
        end

        if (cmd.emit_load)
        begin
            k_next = k_reg + POS_W'(1);
        end

        if (cmd.emit_load || cmd.empty_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            len_a_next = '0;
            len_b_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_a_reg     <= '0;
            len_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_a_reg     <= len_a_next;
            len_b_reg     <= len_b_next;
            ovf_reg       <= ovf_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_reg      <= fr_next;
        fc_reg      <= fc_next;
        s1_r_reg    <= s1_r_next;
        s1_c_reg    <= s1_c_next;
        byp_reg     <= byp_next;
        byp_val_reg <= byp_val_next;
        left_reg    <= left_next;
        diag_reg    <= diag_next;
        tb_r_reg    <= tb_r_next;
        tb_c_reg    <= tb_c_next;
        pos_reg     <= pos_next;
        total_reg   <= total_next;
        k_reg       <= k_next;
        if (a_wr)
        begin
            a_str_reg[IDX_W'(len_a_reg)] <= symbol;
        end
        if (b_wr)
        begin
            b_str_reg[IDX_W'(len_b_reg)] <= symbol;
        end
        if (cmd.emit_load)
        begin
            out_symbol_reg <= buf_rd_reg;
            out_total_reg  <= total_reg;
            out_last_reg   <= emit_last;
            out_empty_reg  <= 1'b0;
            out_ovf_reg    <= ovf_reg;
        end
        else if (cmd.empty_load)
        begin
            out_symbol_reg <= '0;
            out_total_reg  <= '0;
            out_last_reg   <= 1'b1;
            out_empty_reg  <= 1'b1;
            out_ovf_reg    <= ovf_reg;
        end
    end

    // LCS table: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            tbl_mem[tbl_waddr] <= cell_val;
        end
        if (cmd.fill_issue || cmd.tb_read)
        begin
            tbl_rd_a_reg <= tbl_mem[tbl_raddr_a];
        end
        if (cmd.tb_read)
        begin
            tbl_rd_b_reg <= tbl_mem[tbl_raddr_b];
        end
    end

    // output buffer: filled back to front, read front to back
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[POS_W'(pos_reg - TOT_W'(1))] <= buf_wdata;
        end
        if (cmd.emit_read)
        begin
            buf_rd_reg <= buf_mem[k_reg];
        end
    end

    assign sts.both_empty = (len_a_reg == '0) && (len_b_reg == '0);
    assign sts.skip_fill  = (len_a_reg == '0) || (len_b_reg == '0);
    assign sts.fill_last  = (fr_reg == len_a_reg) && (fc_reg == len_b_reg);
    assign sts.tb_both    = (tb_r_reg != '0) && (tb_c_reg != '0);
    assign sts.tb_any     = (tb_r_reg != '0) || (tb_c_reg != '0);
    assign sts.emit_last  = emit_last;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign out_symbol   = out_symbol_reg;
    assign total_length = scs_pkg::TOT_LEN_W'(out_total_reg);
    assign last_symbol  = out_last_reg;
    assign is_empty     = out_empty_reg;
    assign overflowed   = out_ovf_reg;

endmodule

// ===== hw/rtl/shortest_common_supersequence.sv =====
// ----------------------------------------------------------------------------
// shortest_common_supersequence: SCS of two loaded byte strings
// Append items are taken only while idle. A run holds the input through the table
// fill, the trace-back steps inside the table, the leftover symbols and the output
// items, and for as long as the result side stalls; the LCS table fill does one
// cell per cycle on one memory read port. Async active-low reset empties both
// strings and the flag.
// ----------------------------------------------------------------------------
module shortest_common_supersequence #(
    parameter int MAX_LEN = scs_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [scs_pkg::ACT_W-1:0]       action,
    input  logic [scs_pkg::SYM_W-1:0]       symbol,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [scs_pkg::SYM_W-1:0]       out_symbol,
    output logic [scs_pkg::TOT_LEN_W-1:0]   total_length,
    output logic                            last_symbol,
    output logic                            is_empty,
    output logic                            overflowed
);

    // The controller walks the run through its phases:
    //   fill      - one table cell per cycle, row by row; the cell above comes
    //               from the table memory or a forwarding register, left and diagonal from registers
    //   trace     - read the cells above and to the left, then step back
    //   leftover  - copy whatever remains of either string, one per cycle
    //   emit      - read the output buffer front to back into the result
    //               register, one item per free slot
    // Items are taken only while idle; a result still waiting in the output
    // register does not block appends.
    scs_pkg::cmd_t cmd;
    scs_pkg::sts_t sts;

    scs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .sts      (sts),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Datapath owns every counter and store; the controller sees only status.
    scs_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol       (symbol),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_symbol   (out_symbol),
        .total_length (total_length),
        .last_symbol  (last_symbol),
        .is_empty     (is_empty),
        .overflowed   (overflowed)
    );

`ifndef NO_ASSERTIONS
    // a run item takes the block out of idle at once
    a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == scs_pkg::ACT_RUN) |=> in_stall)
        else $error("run item accepted but input not stalled afterwards");

    // result register loads only from a buffer read issued the cycle before
    a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> $past(cmd.emit_read))
        else $error("result loaded without a preceding buffer read");

    // trace-back decision only on table data fetched the cycle before
    a_tb_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tb_step |-> $past(cmd.tb_read))
        else $error("trace-back step without table read");

    // both strings are empty right after a run completes
    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> sts.both_empty)
        else $error("strings not cleared after run");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the supersequence block
// Loads pairs of byte strings, runs the merge and checks every emitted item
// against an in-bench supersequence predictor or a directed row's own answer,
// with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SCS_MAX     = scs_pkg::MAX_LEN_DEF;
    localparam int ACT_W       = scs_pkg::ACT_W;
    localparam int SYM_W       = scs_pkg::SYM_W;
    localparam int TOT_LEN_W   = scs_pkg::TOT_LEN_W;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG    = 8000;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 40;
    // action code that the block ignores
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    // one emitted supersequence item
    typedef struct packed {
        logic [SYM_W-1:0]     sym;
        logic [TOT_LEN_W-1:0] total;
        logic                 last;
        logic                 empty;
        logic                 ovf;
    } scs_res_t;

    // one row of the directed stimulus; typed rows carry their own answer
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [SYM_W-1:0] sym;
        logic             typed;
        scs_res_t         res;
    } dir_row_t;

    localparam scs_res_t NO_RES    = '0;
    localparam scs_res_t RES_EMPTY = '{8'h00, 7'd0, 1'b1, 1'b1, 1'b0};
    localparam scs_res_t RES_ONE00 = '{8'h00, 7'd1, 1'b1, 1'b0, 1'b0};
    localparam scs_res_t RES_ONEFF = '{8'hFF, 7'd1, 1'b1, 1'b0, 1'b0};

    localparam int DIR_N = 25;

    // Directed part: empty runs, ignored actions, single symbols at both
    // extremes, a lone match, and short strings checked by the predictor.
    dir_row_t dir_rows [DIR_N] = '{
        '{scs_pkg::ACT_RUN,      8'h00, 1'b1, RES_EMPTY},   // run right after reset
        '{ACT_NONE,              8'hAA, 1'b0, NO_RES},      // ignored action
        '{scs_pkg::ACT_RUN,      8'hFF, 1'b1, RES_EMPTY},   // still empty, symbol ignored
        '{scs_pkg::ACT_APPEND_A, 8'hFF, 1'b0, NO_RES},
        '{scs_pkg::ACT_RUN,      8'h00, 1'b1, RES_ONEFF},   // first string only
        '{scs_pkg::ACT_APPEND_B, 8'h00, 1'b0, NO_RES},
        '{scs_pkg::ACT_RUN,      8'hFF, 1'b1, RES_ONE00},   // second string only
        '{scs_pkg::ACT_APPEND_A, 8'h00, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_B, 8'h00, 1'b0, NO_RES},
        '{scs_pkg::ACT_RUN,      8'h00, 1'b1, RES_ONE00},   // single shared symbol
        '{scs_pkg::ACT_APPEND_A, 8'h80, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_B, 8'h01, 1'b0, NO_RES},
        '{scs_pkg::ACT_RUN,      8'h00, 1'b0, NO_RES},      // no match, tie on trace
        '{scs_pkg::ACT_APPEND_A, 8'h55, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_A, 8'hAA, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_B, 8'hAA, 1'b0, NO_RES},
        '{ACT_NONE,              8'h00, 1'b0, NO_RES},      // ignored between appends
        '{scs_pkg::ACT_APPEND_B, 8'h55, 1'b0, NO_RES},
        '{scs_pkg::ACT_RUN,      8'h00, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_A, 8'h12, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_A, 8'h34, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_A, 8'h12, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_B, 8'h34, 1'b0, NO_RES},
        '{scs_pkg::ACT_APPEND_B, 8'h12, 1'b0, NO_RES},
        '{scs_pkg::ACT_RUN,      8'h00, 1'b0, NO_RES}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [ACT_W-1:0]     action;
    logic [SYM_W-1:0]     symbol;
    logic                 out_valid;
    logic                 out_stall;
    logic [SYM_W-1:0]     out_symbol;
    logic [TOT_LEN_W-1:0] total_length;
    logic                 last_symbol;
    logic                 is_empty;
    logic                 overflowed;

    // predictor state
    logic [SYM_W-1:0] str_a [SCS_MAX];
    logic [SYM_W-1:0] str_b [SCS_MAX];
    int               len_a;
    int               len_b;
    logic             ovf_flag;
    int               lcs [SCS_MAX+1][SCS_MAX+1];
    logic [SYM_W-1:0] merged [2*SCS_MAX];
    scs_res_t         scs_out [2*SCS_MAX];

    // items still owed by the block, oldest first
    scs_res_t         pending_q[$];
    scs_res_t         head_res;

    int               fail_count;
    int               work_items;
    int               quiet_cycles;
    bit               idle_on;
    bit               stall_on;
    bit               hold_req;

    shortest_common_supersequence uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_symbol   (out_symbol),
        .total_length (total_length),
        .last_symbol  (last_symbol),
        .is_empty     (is_empty),
        .overflowed   (overflowed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one accepted item to the predictor; fill scs_out with the items it
    // causes and return how many there are.
    function automatic int scs_apply(input logic [ACT_W-1:0] act,
                                     input logic [SYM_W-1:0] sym);
        int n, m, r, c, total, pos, up, lft;
        if (act == scs_pkg::ACT_APPEND_A)
        begin
            if (len_a < SCS_MAX)
            begin
                str_a[len_a] = sym;
                len_a++;
            end
            else
                ovf_flag = 1'b1;
            return 0;
        end
        if (act == scs_pkg::ACT_APPEND_B)
        begin
            if (len_b < SCS_MAX)
            begin
                str_b[len_b] = sym;
                len_b++;
            end
            else
                ovf_flag = 1'b1;
            return 0;
        end
        if (act != scs_pkg::ACT_RUN)
            return 0;

        n = len_a;
        m = len_b;
        if (n == 0 && m == 0)
        begin
            scs_out[0] = '{8'h00, 7'd0, 1'b1, 1'b1, ovf_flag};
            ovf_flag = 1'b0;
            return 1;
        end

        // LCS table, row and column zero cleared
        for (r = 0; r <= n; r++)
            lcs[r][0] = 0;
        for (c = 0; c <= m; c++)
            lcs[0][c] = 0;
        for (r = 1; r <= n; r++)
            for (c = 1; c <= m; c++)
            begin
                if (str_a[r-1] == str_b[c-1])
                    lcs[r][c] = lcs[r-1][c-1] + 1;
                else
                begin
                    up  = lcs[r-1][c];
                    lft = lcs[r][c-1];
                    lcs[r][c] = (up > lft) ? up : lft;
                end
            end

        total = n + m - lcs[n][m];

        // walk back from the corner, building the merge from its end
        pos = total;
        r = n;
        c = m;
        while (r > 0 && c > 0)
        begin
            pos--;
            if (str_a[r-1] == str_b[c-1])
            begin
                merged[pos] = str_a[r-1];
                r--;
                c--;
            end
            else if (lcs[r-1][c] > lcs[r][c-1])
            begin
                merged[pos] = str_a[r-1];
                r--;
            end
            else
            begin
                merged[pos] = str_b[c-1];
                c--;
            end
        end
        while (r > 0)
        begin
            pos--;
            merged[pos] = str_a[r-1];
            r--;
        end
        while (c > 0)
        begin
            pos--;
            merged[pos] = str_b[c-1];
            c--;
        end

        for (int k = 0; k < total; k++)
            scs_out[k] = '{merged[k], TOT_LEN_W'(total), (k == total - 1), 1'b0, ovf_flag};

        len_a = 0;
        len_b = 0;
        ovf_flag = 1'b0;
        return total;
    endfunction

    // Offer one item, hold it until accepted, then log what it should cause.
    // Typed rows queue their own answer in place of the predicted one.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                             input logic typed, input scs_res_t typed_res);
        int cnt;
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        symbol   <= sym;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        cnt = scs_apply(act, sym);
        if (typed)
            pending_q.push_back(typed_res);
        else
            for (int k = 0; k < cnt; k++)
                pending_q.push_back(scs_out[k]);
        if (act != ACT_NONE)
            work_items++;
        // drop valid for a random burst now and then
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 12))
                @(negedge clk);
        end
    endtask

    // Drop valid and hold until the block has delivered everything owed.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Load two strings with interleaved appends (counts above the string size
    // overflow), sprinkle ignored actions, then run. Small alphabets give many
    // matches; a full alphabet toggles every symbol bit.
    task automatic load_and_run(input int na, input int nb, input int alpha);
        int               ra;
        int               rb;
        int               base;
        logic [SYM_W-1:0] s;
        bit               pick_a;
        ra = na;
        rb = nb;
        base = (alpha >= 256) ? 0 : $urandom_range(0, 256 - alpha);
        while (ra > 0 || rb > 0)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(ACT_NONE, SYM_W'($urandom_range(0, 255)), 1'b0, NO_RES);
            pick_a = (rb == 0) || (ra > 0 && $urandom_range(0, 1) == 1);
            s = SYM_W'(base + $urandom_range(0, alpha - 1));
            if (pick_a)
            begin
                send_item(scs_pkg::ACT_APPEND_A, s, 1'b0, NO_RES);
                ra--;
            end
            else
            begin
                send_item(scs_pkg::ACT_APPEND_B, s, 1'b0, NO_RES);
                rb--;
            end
        end
        send_item(scs_pkg::ACT_RUN, SYM_W'($urandom_range(0, 255)), 1'b0, NO_RES);
    endtask

    // Mostly short strings, now and then full length or past the limit.
    function automatic int pick_len();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel == 0)
            return $urandom_range(0, SCS_MAX);
        if (sel == 1)
            return $urandom_range(SCS_MAX + 1, SCS_MAX + 3);
        return $urandom_range(0, 8);
    endfunction

    function automatic int pick_alpha();
        unique case ($urandom_range(0, 3))
            0: return 2;
            1: return 4;
            2: return 16;
            default: return 256;
        endcase
    endfunction

    // Result side: random stall bursts, plus one long hold when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (int h = 0; h < HOLD_CYCLES; h++)
                    @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13))
                    @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check each accepted result against the oldest item owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("%0t: unexpected item: sym %02h len %0d last %0b empty %0b ovf %0b",
                             $time, out_symbol, total_length, last_symbol, is_empty,
                             overflowed);
                fail_count++;
            end
            else
            begin
                head_res = pending_q.pop_front();
                if (out_symbol !== head_res.sym || total_length !== head_res.total ||
                    last_symbol !== head_res.last || is_empty !== head_res.empty ||
                    overflowed !== head_res.ovf)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display({"%0t: mismatch: expected sym %02h len %0d last %0b ",
                                  "empty %0b ovf %0b, got sym %02h len %0d last %0b ",
                                  "empty %0b ovf %0b"},
                                 $time, head_res.sym, head_res.total, head_res.last,
                                 head_res.empty, head_res.ovf, out_symbol, total_length,
                                 last_symbol, is_empty, overflowed);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t: timeout, %0d items still owed", $time, pending_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = scs_pkg::ACT_APPEND_A;
        symbol       = '0;
        fail_count   = 0;
        work_items   = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        stall_on     = 1'b1;
        hold_req     = 1'b0;
        len_a        = 0;
        len_b        = 0;
        ovf_flag     = 1'b0;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        for (int i = 0; i < DIR_N; i++)
            send_item(dir_rows[i].act, dir_rows[i].sym, dir_rows[i].typed, dir_rows[i].res);
        wait_drained();

        // full strings with overflow on both sides, full alphabet
        load_and_run(SCS_MAX + 2, SCS_MAX + 1, 256);
        // full strings, two symbols: long trace with many matches
        load_and_run(SCS_MAX, SCS_MAX, 2);
        // first string overflows, second stays empty
        load_and_run(SCS_MAX + 1, 0, 256);
        // second string only, at full length
        load_and_run(0, SCS_MAX, 16);

        // Hold the result side for a long stretch while items keep coming, so
        // the block backs up and stalls its input; then drain completely.
        hold_req = 1'b1;
        load_and_run(6, 5, 4);
        load_and_run(4, 7, 256);
        load_and_run(3, 3, 2);
        wait_drained();

        // random part
        while (work_items < 230)
        begin
            load_and_run(pick_len(), pick_len(), pick_alpha());
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        // last stretch at full rate on both sides
        idle_on  = 1'b0;
        stall_on = 1'b0;
        while (work_items < 270)
            load_and_run($urandom_range(0, 6), $urandom_range(0, 6), pick_alpha());

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (pending_q.size() != 0)
        begin
            $display("%0t: %0d items never delivered", $time, pending_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
